// ===== hdl/crcd_pkg.sv =====
// Shared constants, types and helpers for the clock replacement cache directory.
package crcd_pkg;

    localparam int ENTRIES     = 64;
    localparam int MAX_RESULTS = 64;
    localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W       = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
    localparam int SECTOR_W    = 32;
    localparam int KIND_W      = 2;
    localparam int OUT_IDX_W   = 6;

    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_RESULTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_HIT,
        ST_SWEEP,
        ST_INSTALL,
        ST_FSCAN,
        ST_FEMIT
    } crcd_state_t;

    typedef struct packed {
        logic capture;      // latch kind and sector of an accepted transfer
        logic scan_start;   // clear scan index, pipeline flag and flush count
        logic rd_en;        // read tag memory into the read register
        logic rd_hand;      // read address is the clock hand, else scan index
        logic search_step;  // advance the search pipeline
        logic hit_load;     // update flags of hit entry and load result
        logic sweep_pass;   // clear accessed mark at hand and move on
        logic install;      // write new tag and flags at hand, load result
        logic flush_load;   // clear dirty mark at scan index, load result
        logic idx_step;     // move scan index past a clean entry
    } crcd_cmd_t;

    typedef struct packed {
        logic hit_found;
        logic search_end;
        logic sweep_take;
        logic flush_found;
        logic idx_last;
        logic flush_final;
        logic out_free;
    } crcd_stat_t;

    function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] p);
        return (p == IDX_LAST) ? '0 : p + IDX_W'(1);
    endfunction

    function automatic logic [OUT_IDX_W-1:0] out_index(input logic [IDX_W-1:0] p);
        logic [IDX_W+OUT_IDX_W-1:0] ext;
        ext = {{OUT_IDX_W{1'b0}}, p};
        return ext[OUT_IDX_W-1:0];
    endfunction

endpackage

// ===== hdl/crcd_ctrl.sv =====
// Sequencer for search, clock sweep, install and flush of the cache directory.
module crcd_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic [crcd_pkg::KIND_W-1:0]  s_kind,
    output logic                         s_ready,
    input  crcd_pkg::crcd_stat_t         stat,
    output crcd_pkg::crcd_cmd_t          cmd
);

    crcd_pkg::crcd_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= crcd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            crcd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture    = 1'b1;
                    cmd.scan_start = 1'b1;
                    if (s_kind inside {crcd_pkg::KIND_READ, crcd_pkg::KIND_WRITE}) begin
                        state_next = crcd_pkg::ST_SEARCH;
                    end else if (s_kind == crcd_pkg::KIND_FLUSH) begin
                        state_next = crcd_pkg::ST_FSCAN;
                    end
                end
            end
            crcd_pkg::ST_SEARCH: begin
                if (stat.hit_found) begin
                    state_next = crcd_pkg::ST_HIT;
                end else if (stat.search_end) begin
                    state_next = crcd_pkg::ST_SWEEP;
                end else begin
                    cmd.rd_en       = 1'b1;
                    cmd.search_step = 1'b1;
                end
            end
            crcd_pkg::ST_HIT: begin
                if (stat.out_free) begin
                    cmd.hit_load = 1'b1;
                    state_next   = crcd_pkg::ST_IDLE;
                end
            end
            crcd_pkg::ST_SWEEP: begin
                if (stat.sweep_take) begin
                    // fetch the victim tag at the hand
                    cmd.rd_en   = 1'b1;
                    cmd.rd_hand = 1'b1;
                    state_next  = crcd_pkg::ST_INSTALL;
                end else begin
                    cmd.sweep_pass = 1'b1;
                end
            end
            crcd_pkg::ST_INSTALL: begin
                if (stat.out_free) begin
                    cmd.install = 1'b1;
                    state_next  = crcd_pkg::ST_IDLE;
                end
            end
            crcd_pkg::ST_FSCAN: begin
                if (stat.flush_found) begin
                    cmd.rd_en  = 1'b1;
                    state_next = crcd_pkg::ST_FEMIT;
                end else if (stat.idx_last) begin
                    state_next = crcd_pkg::ST_IDLE;
                end else begin
                    cmd.idx_step = 1'b1;
                end
            end
            crcd_pkg::ST_FEMIT: begin
                if (stat.out_free) begin
                    cmd.flush_load = 1'b1;
                    state_next = stat.flush_final ? crcd_pkg::ST_IDLE : crcd_pkg::ST_FSCAN;
                end
            end
            default: begin
                state_next = crcd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/crcd_dp.sv =====
// Tag memory, entry flags, clock hand, scan counters and result register.
module crcd_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [crcd_pkg::KIND_W-1:0]     s_kind,
    input  logic [crcd_pkg::SECTOR_W-1:0]   s_sector,
    input  crcd_pkg::crcd_cmd_t             cmd,
    output crcd_pkg::crcd_stat_t            stat,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [crcd_pkg::OUT_IDX_W-1:0]  m_entry_index,
    output logic                            m_hit,
    output logic                            m_fill_needed,
    output logic                            m_write_back,
    output logic [crcd_pkg::SECTOR_W-1:0]   m_victim_sector,
    output logic                            m_last
);

    logic [crcd_pkg::SECTOR_W-1:0] tag_mem [crcd_pkg::ENTRIES];

    logic [crcd_pkg::ENTRIES-1:0]  valid_reg, valid_next;
    logic [crcd_pkg::ENTRIES-1:0]  dirty_reg, dirty_next;
    logic [crcd_pkg::ENTRIES-1:0]  ref_reg, ref_next;
    logic [crcd_pkg::IDX_W-1:0]    hand_reg, hand_next;
    logic [crcd_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [crcd_pkg::IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                          rd_ok_reg, rd_ok_next;
    logic [crcd_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [crcd_pkg::KIND_W-1:0]   kind_reg;
    logic [crcd_pkg::SECTOR_W-1:0] sector_reg;
    logic [crcd_pkg::SECTOR_W-1:0] rdata_reg;
    logic [crcd_pkg::IDX_W-1:0]    rd_addr;

    logic                          m_valid_reg, m_valid_next;
    logic [crcd_pkg::OUT_IDX_W-1:0] entry_reg, entry_next;
    logic                          hit_reg, hit_next;
    logic                          fill_reg, fill_next;
    logic                          wb_reg, wb_next;
    logic [crcd_pkg::SECTOR_W-1:0] victim_reg, victim_next;
    logic                          last_reg, last_next;

    logic [crcd_pkg::ENTRIES-1:0]  pend_above;
    logic                          victim_dirty;

    assign rd_addr = cmd.rd_hand ? hand_reg : idx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.install) begin
            tag_mem[hand_reg] <= sector_reg;
        end
        if (cmd.rd_en) begin
            rdata_reg <= tag_mem[rd_addr];
        end
    end

    // dirty entries above the scan index, for the final-result flag
    always_comb begin
        for (int j = 0; j < crcd_pkg::ENTRIES; j++) begin
            pend_above[j] = valid_reg[j] && dirty_reg[j]
                            && (crcd_pkg::IDX_W'(j) > idx_reg);
        end
    end

    assign victim_dirty = valid_reg[hand_reg] && dirty_reg[hand_reg];

    always_comb begin
        stat.hit_found   = rd_ok_reg && valid_reg[rd_idx_reg] && (rdata_reg == sector_reg);
        stat.search_end  = rd_ok_reg && (rd_idx_reg == crcd_pkg::IDX_LAST);
        stat.sweep_take  = !valid_reg[hand_reg] || !ref_reg[hand_reg];
        stat.flush_found = valid_reg[idx_reg] && dirty_reg[idx_reg];
        stat.idx_last    = (idx_reg == crcd_pkg::IDX_LAST);
        stat.flush_final = !(|pend_above) || (cnt_reg == crcd_pkg::CNT_LAST);
        stat.out_free    = !m_valid_reg || m_ready;
    end

    always_comb begin
        valid_next   = valid_reg;
        dirty_next   = dirty_reg;
        ref_next     = ref_reg;
        hand_next    = hand_reg;
        idx_next     = idx_reg;
        rd_idx_next  = rd_idx_reg;
        rd_ok_next   = rd_ok_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        entry_next   = entry_reg;
        hit_next     = hit_reg;
        fill_next    = fill_reg;
        wb_next      = wb_reg;
        victim_next  = victim_reg;
        last_next    = last_reg;

        if (cmd.scan_start) begin
            idx_next   = '0;
            rd_ok_next = 1'b0;
            cnt_next   = '0;
        end
        if (cmd.search_step) begin
            rd_idx_next = idx_reg;
            rd_ok_next  = 1'b1;
            idx_next    = crcd_pkg::next_pos(idx_reg);
        end
        if (cmd.idx_step) begin
            idx_next = crcd_pkg::next_pos(idx_reg);
        end
        if (cmd.hit_load) begin
            ref_next[rd_idx_reg] = 1'b1;
            if (kind_reg == crcd_pkg::KIND_WRITE) begin
                dirty_next[rd_idx_reg] = 1'b1;
            end
            m_valid_next = 1'b1;
            entry_next   = crcd_pkg::out_index(rd_idx_reg);
            hit_next     = 1'b1;
            fill_next    = 1'b0;
            wb_next      = 1'b0;
            victim_next  = '0;
            last_next    = 1'b1;
        end
        if (cmd.sweep_pass) begin
            ref_next[hand_reg] = 1'b0;
            hand_next          = crcd_pkg::next_pos(hand_reg);
        end
        if (cmd.install) begin
            valid_next[hand_reg] = 1'b1;
            ref_next[hand_reg]   = 1'b1;
            dirty_next[hand_reg] = (kind_reg == crcd_pkg::KIND_WRITE);
            hand_next            = crcd_pkg::next_pos(hand_reg);
            m_valid_next         = 1'b1;
            entry_next           = crcd_pkg::out_index(hand_reg);
            hit_next             = 1'b0;
            fill_next            = (kind_reg == crcd_pkg::KIND_READ);
            wb_next              = victim_dirty;
            victim_next          = victim_dirty ? rdata_reg : '0;
            last_next            = 1'b1;
        end
        if (cmd.flush_load) begin
            dirty_next[idx_reg] = 1'b0;
            idx_next            = crcd_pkg::next_pos(idx_reg);
            cnt_next            = cnt_reg + crcd_pkg::CNT_W'(1);
            m_valid_next        = 1'b1;
            entry_next          = crcd_pkg::out_index(idx_reg);
            hit_next            = 1'b0;
            fill_next           = 1'b0;
            wb_next             = 1'b1;
            victim_next         = rdata_reg;
            last_next           = stat.flush_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            dirty_reg   <= '0;
            ref_reg     <= '0;
            hand_reg    <= '0;
            rd_ok_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            dirty_reg   <= dirty_next;
            ref_reg     <= ref_next;
            hand_reg    <= hand_next;
            rd_ok_reg   <= rd_ok_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        rd_idx_reg <= rd_idx_next;
        cnt_reg    <= cnt_next;
        entry_reg  <= entry_next;
        hit_reg    <= hit_next;
        fill_reg   <= fill_next;
        wb_reg     <= wb_next;
        victim_reg <= victim_next;
        last_reg   <= last_next;
        if (cmd.capture) begin
            kind_reg   <= s_kind;
            sector_reg <= s_sector;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_entry_index   = entry_reg;
    assign m_hit           = hit_reg;
    assign m_fill_needed   = fill_reg;
    assign m_write_back    = wb_reg;
    assign m_victim_sector = victim_reg;
    assign m_last          = last_reg;

    a_hit_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && hit_reg |-> !fill_reg && !wb_reg && last_reg)
        else $error("hit result carries fill or write-back");

    a_victim_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !wb_reg |-> victim_reg == '0)
        else $error("victim sector set without write-back");

    a_install_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.install |=> valid_reg[$past(hand_reg)] && ref_reg[$past(hand_reg)])
        else $error("installed entry not valid and accessed");

    a_hand_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hand_reg <= crcd_pkg::IDX_LAST)
        else $error("clock hand out of range");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.hit_load || cmd.install || cmd.flush_load) |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while held");

endmodule

// ===== hdl/clock_replacement_cache_directory.sv =====
// Top level of the clock replacement cache directory.
//
//  channel   | ports                                          | direction
//  ----------+------------------------------------------------+----------
//  request   | s_valid s_ready s_kind s_sector                | in
//  result    | m_valid m_ready m_entry_index m_hit            | out
//            | m_fill_needed m_write_back m_victim_sector m_last |
//
// A request is taken only while the sequencer is idle; the held result does not block it.
// Read/write: tag search over one memory read per entry.
// A miss runs the full search and up to ENTRIES sweep passes, then fetches the victim
// tag and installs the new one.
// Flush: scans the entries in index order and reports each dirty entry.
// Synchronous active-low reset clears all entry flags, the hand and the result valid.
// A stalled result channel holds the sequencer until the result register frees up.
module clock_replacement_cache_directory (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [crcd_pkg::KIND_W-1:0]     s_kind,
    input  logic [crcd_pkg::SECTOR_W-1:0]   s_sector,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [crcd_pkg::OUT_IDX_W-1:0]  m_entry_index,
    output logic                            m_hit,
    output logic                            m_fill_needed,
    output logic                            m_write_back,
    output logic [crcd_pkg::SECTOR_W-1:0]   m_victim_sector,
    output logic                            m_last
);

    crcd_pkg::crcd_cmd_t  cmd;
    crcd_pkg::crcd_stat_t stat;

    crcd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    crcd_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_kind          (s_kind),
        .s_sector        (s_sector),
        .cmd             (cmd),
        .stat            (stat),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_entry_index   (m_entry_index),
        .m_hit           (m_hit),
        .m_fill_needed   (m_fill_needed),
        .m_write_back    (m_write_back),
        .m_victim_sector (m_victim_sector),
        .m_last          (m_last)
    );

endmodule
